// ----- hdl/bpwl_pkg.sv -----
// Package for the bounded priority work list: request/response types,
// command and status codes, entry key type and the priority compare.
// No dependencies.
`default_nettype none

package bpwl_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;
  localparam int TAG_PORT_W   = 16;
  localparam int COUNT_PORT_W = 5;
  localparam int WRAP_LIMIT   = 10;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_REJECTED = 3'd2,
    ST_POPPED   = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic [7:0]              grade;
    logic [7:0]              seq_first;
    logic [23:0]             seq_rest;
    logic [TAG_PORT_W-1:0]   tag;
  } in_req_t;

  typedef struct packed {
    status_e                 status;
    logic [TAG_PORT_W-1:0]   out_tag;
    logic [7:0]              out_grade;
    logic [COUNT_PORT_W-1:0] count;
  } out_rsp_t;

  // Sort key of one held entry.
  typedef struct packed {
    logic [7:0]  grade;
    logic [7:0]  seq_first;
    logic [23:0] seq_rest;
  } key_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic ins_en;  // insert of an accepted, in-range entry
    logic pop_en;  // pop of a non-empty list
    logic valid;   // cell holds a live entry
  } cell_ctrl_t;

  // True when new key n strictly outranks held key h.
  function automatic logic prio_beats(key_t n, key_t h);
    logic signed [8:0] d;
    logic signed [8:0] lim;
    logic              r;
    lim = 9'(WRAP_LIMIT);
    d   = $signed({1'b0, h.seq_first}) - $signed({1'b0, n.seq_first});
    if (n.grade != h.grade) begin
      r = (n.grade < h.grade);
    end else if (d != 9'sd0) begin
      // large gap on the first byte means the sequence wrapped
      if (d > lim || d < -lim) begin
        r = (d < 9'sd0);
      end else begin
        r = (d > 9'sd0);
      end
    end else begin
      r = (n.seq_rest < h.seq_rest);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bpwl_cell.sv -----
// One slot of the sorted work list: holds an entry, compares it with the
// incoming one and loads from the new entry or either neighbor.
// Depends on bpwl_pkg.
`default_nettype none

module bpwl_cell import bpwl_pkg::*; #(
  parameter int TAG_W = TAG_BITS_DEF
) (
  input  wire              clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  key_t             new_key_i,
  input  wire [TAG_W-1:0]  new_tag_i,
  input  key_t             prev_key_i,
  input  wire [TAG_W-1:0]  prev_tag_i,
  input  key_t             next_key_i,
  input  wire [TAG_W-1:0]  next_tag_i,
  input  wire              sfx_prev_i,  // insert point at or before left neighbor
  input  wire              sfx_next_i,  // new entry passes every cell to the right
  output logic             sfx_o,
  output key_t             key_o,
  output logic [TAG_W-1:0] tag_o
);

  key_t             key_q, key_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic             beats;

  assign beats = prio_beats(new_key_i, key_q);
  // empty slots are always passed
  assign sfx_o = (!ctrl_i.valid || beats) && sfx_next_i;

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (ctrl_i.ins_en && sfx_prev_i) begin
      key_d = prev_key_i;
      tag_d = prev_tag_i;
    end else if (ctrl_i.ins_en && sfx_o) begin
      key_d = new_key_i;
      tag_d = new_tag_i;
    end else if (ctrl_i.pop_en) begin
      key_d = next_key_i;
      tag_d = next_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

// ----- hdl/bounded_priority_work_list.sv -----
// Top level of the bounded priority work list: request/response channels,
// max_grade register, count and the row of list cells.
// Depends on bpwl_pkg and bpwl_cell.
`default_nettype none

// Bounded priority work list. Holds up to DEPTH entries sorted from highest
// to lowest priority in a row of cells, one entry per cell, head in cell 0.
// Every request is handled whole: insert, pop and clear all complete in the
// cycle they are accepted, and the response is registered and presented
// from the next cycle on, so a new request is taken every cycle as long as
// the response side does not stall. The insert point is found by a flag that
// ripples from the tail of the row toward the head, each cell adding its own
// compare, so the path through the row grows with DEPTH. Entries that were
// never written are never read, so there is no clearing pass after reset;
// clear just zeroes the count. Requests with the reserved command are taken
// and give no response. max_grade is meant to be written only while idle.

module bounded_priority_work_list import bpwl_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  in_req_t    in_req_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output out_rsp_t   out_rsp_o,
  input  wire        cfg_we_i,
  input  wire [7:0]  cfg_wdata_i
);

  // Tags are stored at TAG_BITS, never wider than the port.
  localparam int TAG_W = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       max_grade_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_rsp_t         out_rsp_q, rsp_d;

  logic             in_acc;
  logic             ins_en, pop_en, rsvd;
  key_t             new_key;
  logic [TAG_W-1:0] new_tag;

  key_t             keys [DEPTH];
  logic [TAG_W-1:0] tags [DEPTH];
  // sfx[j]: new entry outranks every live entry from cell j to the tail,
  // i.e. the insert point is at or before cell j.
  logic [DEPTH:0]   sfx;

  logic [CNT_W+COUNT_PORT_W-1:0] cnt_ext;
  logic [TAG_W+TAG_PORT_W-1:0]   tag_ext;

  // A pending response that is stalled holds off new requests; otherwise
  // the output register takes one response every cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign rsvd   = (in_req_i.cmd == CMD_RSVD);
  assign ins_en = in_acc && (in_req_i.cmd == CMD_INSERT) && (in_req_i.grade <= max_grade_q);
  assign pop_en = in_acc && (in_req_i.cmd == CMD_POP) && (count_q != '0);

  assign new_key.grade     = in_req_i.grade;
  assign new_key.seq_first = in_req_i.seq_first;
  assign new_key.seq_rest  = in_req_i.seq_rest;
  assign new_tag           = in_req_i.tag[TAG_W-1:0];

  assign sfx[DEPTH] = 1'b1;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    cell_ctrl_t       ctrl;
    key_t             prev_key, next_key;
    logic [TAG_W-1:0] prev_tag, next_tag;
    logic             sfx_prev;

    assign ctrl.ins_en = ins_en;
    assign ctrl.pop_en = pop_en;
    assign ctrl.valid  = (count_q > CNT_W'(j));

    if (j == 0) begin : g_head
      // head never shifts in from the left
      assign prev_key = new_key;
      assign prev_tag = new_tag;
      assign sfx_prev = 1'b0;
    end else begin : g_body
      assign prev_key = keys[j-1];
      assign prev_tag = tags[j-1];
      assign sfx_prev = sfx[j-1];
    end

    if (j == DEPTH - 1) begin : g_tail
      // tail slot on pop falls outside the new count; hold it
      assign next_key = keys[j];
      assign next_tag = tags[j];
    end else begin : g_mid
      assign next_key = keys[j+1];
      assign next_tag = tags[j+1];
    end

    bpwl_cell #(
      .TAG_W (TAG_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_key_i  (new_key),
      .new_tag_i  (new_tag),
      .prev_key_i (prev_key),
      .prev_tag_i (prev_tag),
      .next_key_i (next_key),
      .next_tag_i (next_tag),
      .sfx_prev_i (sfx_prev),
      .sfx_next_i (sfx[j+1]),
      .sfx_o      (sfx[j]),
      .key_o      (keys[j]),
      .tag_o      (tags[j])
    );
  end

  // Count update. An insert that lands nowhere (full list, new entry
  // lowest) leaves sfx[DEPTH-1] low and changes nothing.
  always_comb begin
    count_d = count_q;
    if (in_acc) begin
      case (in_req_i.cmd)
        CMD_INSERT: begin
          if (ins_en && sfx[DEPTH-1] && (count_q < CNT_W'(DEPTH))) begin
            count_d = count_q + CNT_W'(1);
          end
        end
        CMD_POP: begin
          if (pop_en) begin
            count_d = count_q - CNT_W'(1);
          end
        end
        CMD_CLEAR: count_d = '0;
        default:   count_d = count_q;
      endcase
    end
  end

  assign cnt_ext = {{COUNT_PORT_W{1'b0}}, count_d};
  assign tag_ext = {{TAG_PORT_W{1'b0}}, tags[0]};

  // Response for the request taken this cycle.
  always_comb begin
    rsp_d           = '0;
    rsp_d.count     = cnt_ext[COUNT_PORT_W-1:0];
    case (in_req_i.cmd)
      CMD_INSERT: begin
        if (!ins_en) begin
          rsp_d.status = ST_REJECTED;
        end else if (sfx[DEPTH-1]) begin
          rsp_d.status = ST_INSERTED;
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      CMD_POP: begin
        if (pop_en) begin
          rsp_d.status    = ST_POPPED;
          rsp_d.out_tag   = tag_ext[TAG_PORT_W-1:0];
          rsp_d.out_grade = keys[0].grade;
        end else begin
          rsp_d.status = ST_EMPTY;
        end
      end
      default: rsp_d.status = ST_CLEARED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_grade_q <= 8'hFF;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_grade_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (in_acc && !rsvd) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // response payload, loaded only with a new response
  always_ff @(posedge clk_i) begin
    if (in_acc && !rsvd) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list count above depth");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_en |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not remove one entry");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !rsvd) |=> out_valid_q)
    else $error("accepted request gave no response");

  a_rsvd_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && rsvd) |=> (count_q == $past(count_q)))
    else $error("reserved command changed the list");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rsp_q.status != ST_POPPED) |->
      (out_rsp_q.out_tag == '0 && out_rsp_q.out_grade == '0))
    else $error("non-pop response carries entry data");

endmodule

`default_nettype wire
